[rtl/sat_pkg.sv]
// Package for the segment address translator: sizes, operation and status codes,
// the segment table entry type and the sequencer states. No dependencies.
package sat_pkg;

    localparam int SEGMENT_SLOTS = 64;
    localparam int CACHE_DEPTH   = 8;

    localparam int ORD_W   = 6;
    localparam int ADDR_W  = 32;
    localparam int HOST_W  = 64;
    localparam int SLOT_W  = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
    localparam int CACHE_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(CACHE_DEPTH + 1);
    localparam int SCAN_W  = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;

    localparam logic [1:0] OP_LOAD       = 2'd0;
    localparam logic [1:0] OP_XLATE_ADDR = 2'd1;
    localparam logic [1:0] OP_XLATE_OFS  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [HOST_W-1:0] mapped;
    } seg_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CACHE,
        S_TABLE,
        S_MAP,
        S_DONE
    } state_t;

endpackage

[rtl/sat_chan_if.sv]
// Valid/ready channel interfaces for the command and result beats of the
// segment address translator. Depends on sat_pkg.
interface sat_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        opcode;
    logic [sat_pkg::ORD_W-1:0]         ordinal;
    logic [sat_pkg::ADDR_W-1:0]        segment_base;
    logic [sat_pkg::ADDR_W-1:0]        segment_size;
    logic [sat_pkg::HOST_W-1:0]        mapped_base;
    logic [sat_pkg::ADDR_W-1:0]        address;
    logic signed [sat_pkg::ADDR_W-1:0] offset;

    modport source (output valid, opcode, ordinal, segment_base, segment_size, mapped_base,
                    address, offset, input ready);
    modport sink (input valid, opcode, ordinal, segment_base, segment_size, mapped_base,
                  address, offset, output ready);
endinterface

interface sat_res_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [sat_pkg::HOST_W-1:0] translated;
    logic                       cache_hit;

    modport source (output valid, status, translated, cache_hit, input ready);
    modport sink (input valid, status, translated, cache_hit, output ready);
endinterface

[rtl/segment_address_translator_top.sv]
// Segment address translator: segment table in a memory, recent-ordinal list
// and a sequencer that scans both with one shared range comparator.
// Depends on sat_pkg and the channel interfaces in sat_chan_if.sv.
//
//   Channel  Direction  Beat
//   cmd      in         opcode, ordinal, segment_base, segment_size, mapped_base,
//                       address, offset
//   res      out        status, translated, cache_hit
//   cfg      in         image_base write (cfg_write, cfg_data)
//
// A load or an unused opcode goes from the accept state straight to S_DONE.
// A translation scans the recent list in S_CACHE, then on a list miss the table in
// S_TABLE; a hit passes through S_MAP to S_DONE. Every compare waits on the one
// registered table read port. A miss ends in S_DONE with status not found.
// Reset clears the valid bits and the list count at once; no clearing pass is needed.
// cmd is not ready until the result beat is taken; a stalled result beat keeps the block busy.
module segment_address_translator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    sat_cmd_if.sink                    cmd,
    sat_res_if.source                  res,
    input  logic                       cfg_write,
    input  logic [sat_pkg::ADDR_W-1:0] cfg_data
);

    sat_pkg::state_t                     state_reg, state_next;
    logic [sat_pkg::ADDR_W-1:0]          image_base_reg;
    logic [sat_pkg::SEGMENT_SLOTS-1:0]   valid_reg, valid_next;
    logic [sat_pkg::SLOT_W-1:0]          recent_reg [sat_pkg::CACHE_DEPTH];
    logic [sat_pkg::SLOT_W-1:0]          recent_next [sat_pkg::CACHE_DEPTH];
    logic [sat_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [sat_pkg::SCAN_W-1:0]          scan_reg, scan_next;
    logic                                rd_cand_reg, rd_cand_next;
    logic [sat_pkg::SLOT_W-1:0]          rd_ord_reg, rd_ord_next;
    logic [sat_pkg::ADDR_W-1:0]          addr_reg, addr_next;
    logic [sat_pkg::ADDR_W-1:0]          diff_reg, diff_next;
    logic [sat_pkg::HOST_W-1:0]          mapped_reg, mapped_next;
    logic [1:0]                          status_reg, status_next;
    logic [sat_pkg::HOST_W-1:0]          translated_reg, translated_next;
    logic                                cache_hit_reg, cache_hit_next;

    sat_pkg::seg_entry_t                 mem [sat_pkg::SEGMENT_SLOTS];
    sat_pkg::seg_entry_t                 mem_rdata_reg;
    sat_pkg::seg_entry_t                 mem_wdata;
    logic                                mem_we;
    logic [sat_pkg::SLOT_W-1:0]          mem_waddr;
    logic [sat_pkg::SLOT_W-1:0]          mem_raddr;

    logic                                accept;
    logic                                ord_ok;
    logic                                issue;
    logic                                in_range;
    logic                                hit;
    logic [sat_pkg::ADDR_W:0]            range_end;
    logic [sat_pkg::CNT_W-1:0]           clamp_count;

    assign accept    = cmd.valid && cmd.ready;
    assign ord_ok    = 32'(cmd.ordinal) < sat_pkg::SEGMENT_SLOTS;
    assign mem_waddr = sat_pkg::SLOT_W'(cmd.ordinal);
    assign mem_wdata = '{base: cmd.segment_base, size: cmd.segment_size,
                         mapped: cmd.mapped_base};
    assign mem_we    = accept && (cmd.opcode == sat_pkg::OP_LOAD) && ord_ok
                       && !valid_reg[mem_waddr];

    // The shared comparator checks the entry read in the previous cycle.
    assign range_end = {1'b0, mem_rdata_reg.base} + {1'b0, mem_rdata_reg.size};
    assign in_range  = (addr_reg >= mem_rdata_reg.base) && ({1'b0, addr_reg} < range_end);
    assign hit       = rd_cand_reg && in_range;

    always_comb
    begin
        issue     = 1'b0;
        mem_raddr = scan_reg[sat_pkg::SLOT_W-1:0];
        case (state_reg)
            sat_pkg::S_CACHE:
            begin
                issue     = scan_reg < sat_pkg::SCAN_W'(count_reg);
                mem_raddr = recent_reg[scan_reg[sat_pkg::CACHE_W-1:0]];
            end
            sat_pkg::S_TABLE:
            begin
                issue = 32'(scan_reg) < sat_pkg::SEGMENT_SLOTS;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sat_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.opcode inside {sat_pkg::OP_XLATE_ADDR, sat_pkg::OP_XLATE_OFS})
                    begin
                        state_next = sat_pkg::S_CACHE;
                    end
                    else
                    begin
                        state_next = sat_pkg::S_DONE;
                    end
                end
            end
            sat_pkg::S_CACHE:
            begin
                if (hit)
                begin
                    state_next = sat_pkg::S_MAP;
                end
                else if (!issue)
                begin
                    state_next = sat_pkg::S_TABLE;
                end
            end
            sat_pkg::S_TABLE:
            begin
                if (hit)
                begin
                    state_next = sat_pkg::S_MAP;
                end
                else if (!issue)
                begin
                    state_next = sat_pkg::S_DONE;
                end
            end
            sat_pkg::S_MAP:
            begin
                state_next = sat_pkg::S_DONE;
            end
            sat_pkg::S_DONE:
            begin
                if (res.ready)
                begin
                    state_next = sat_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next      = valid_reg;
        recent_next     = recent_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        rd_cand_next    = 1'b0;
        rd_ord_next     = rd_ord_reg;
        addr_next       = addr_reg;
        diff_next       = diff_reg;
        mapped_next     = mapped_reg;
        status_next     = status_reg;
        translated_next = translated_reg;
        cache_hit_next  = cache_hit_reg;
        clamp_count     = (32'(count_reg) >= sat_pkg::CACHE_DEPTH)
                          ? sat_pkg::CNT_W'(sat_pkg::CACHE_DEPTH - 1) : count_reg;
        case (state_reg)
            sat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    scan_next       = '0;
                    status_next     = sat_pkg::ST_OK;
                    translated_next = '0;
                    cache_hit_next  = 1'b0;
                    if (cmd.opcode == sat_pkg::OP_XLATE_OFS)
                    begin
                        addr_next = image_base_reg + unsigned'(cmd.offset);
                    end
                    else
                    begin
                        addr_next = cmd.address;
                    end
                    if (cmd.opcode == sat_pkg::OP_LOAD && ord_ok)
                    begin
                        if (valid_reg[mem_waddr])
                        begin
                            status_next = sat_pkg::ST_DUPLICATE;
                        end
                        else
                        begin
                            valid_next[mem_waddr] = 1'b1;
                        end
                    end
                end
            end
            sat_pkg::S_CACHE, sat_pkg::S_TABLE:
            begin
                if (hit)
                begin
                    diff_next      = addr_reg - mem_rdata_reg.base;
                    mapped_next    = mem_rdata_reg.mapped;
                    cache_hit_next = (state_reg == sat_pkg::S_CACHE);
                    // A hit from the full table moves its ordinal to the list front.
                    if (state_reg == sat_pkg::S_TABLE)
                    begin
                        count_next = clamp_count;
                        if (clamp_count == '0 || recent_reg[0] != rd_ord_reg)
                        begin
                            for (int k = 1; k < sat_pkg::CACHE_DEPTH; k++)
                            begin
                                recent_next[k] = recent_reg[k-1];
                            end
                            recent_next[0] = rd_ord_reg;
                            count_next     = clamp_count + 1'b1;
                        end
                    end
                end
                else if (issue)
                begin
                    scan_next    = scan_reg + 1'b1;
                    rd_cand_next = valid_reg[mem_raddr];
                    rd_ord_next  = mem_raddr;
                end
                else if (state_reg == sat_pkg::S_CACHE)
                begin
                    scan_next = '0;
                end
                else
                begin
                    status_next = sat_pkg::ST_NOT_FOUND;
                end
            end
            sat_pkg::S_MAP:
            begin
                translated_next = mapped_reg + sat_pkg::HOST_W'(diff_reg);
            end
            default:
            begin
                rd_cand_next = 1'b0;
            end
        endcase
    end

    assign cmd.ready      = (state_reg == sat_pkg::S_IDLE);
    assign res.valid      = (state_reg == sat_pkg::S_DONE);
    assign res.status     = status_reg;
    assign res.translated = translated_reg;
    assign res.cache_hit  = cache_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sat_pkg::S_IDLE;
            image_base_reg <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            rd_cand_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            rd_cand_reg <= rd_cand_next;
            if (cfg_write)
            begin
                image_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        recent_reg     <= recent_next;
        scan_reg       <= scan_next;
        rd_ord_reg     <= rd_ord_next;
        addr_reg       <= addr_next;
        diff_reg       <= diff_next;
        mapped_reg     <= mapped_next;
        status_reg     <= status_next;
        translated_reg <= translated_next;
        cache_hit_reg  <= cache_hit_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !cmd.ready)
        else $error("Command accepted while a result beat is pending.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= sat_pkg::CACHE_DEPTH)
        else $error("Recent list count exceeds its depth.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("Ready did not drop after a command beat.");

    a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.cache_hit) |-> (res.status == sat_pkg::ST_OK))
        else $error("List hit reported with a failing status.");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != sat_pkg::ST_OK) |-> (res.translated == '0))
        else $error("Failing result carries a non-zero address.");
`endif

endmodule

[tb/sv/sat_xlate_checker.sv]
`timescale 1ns / 100ps
// Monitor and predictor for the segment address translator: it follows command,
// result and image base write traffic, predicts each result beat and compares it.
// Depends on sat_pkg and the channel interfaces in sat_chan_if.sv.
module sat_xlate_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    sat_cmd_if                         cmd,
    sat_res_if                         res,
    input  logic                       cfg_write,
    input  logic [sat_pkg::ADDR_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending,
    output int                         recent_hits,
    output int                         misses
);

    typedef struct packed {
        logic [1:0]                 status;
        logic [sat_pkg::HOST_W-1:0] translated;
        logic                       cache_hit;
    } xlate_result_t;

    logic                       seg_valid [sat_pkg::SEGMENT_SLOTS];
    sat_pkg::seg_entry_t        seg_tab [sat_pkg::SEGMENT_SLOTS];
    logic [sat_pkg::ORD_W-1:0]  mru_list [$];
    logic [sat_pkg::ADDR_W-1:0] image_base;
    xlate_result_t              expected_q [$];
    int                         errors = 0;
    int                         hit_count = 0;
    int                         miss_count = 0;

    function automatic logic seg_covers(input int idx,
                                        input logic [sat_pkg::ADDR_W-1:0] addr);
        logic [sat_pkg::ADDR_W:0] lo;
        logic [sat_pkg::ADDR_W:0] hi;
        lo = {1'b0, seg_tab[idx].base};
        hi = lo + {1'b0, seg_tab[idx].size};
        return seg_valid[idx] && ({1'b0, addr} >= lo) && ({1'b0, addr} < hi);
    endfunction

    function automatic xlate_result_t resolve_address(input logic [sat_pkg::ADDR_W-1:0] addr);
        xlate_result_t              r;
        logic [sat_pkg::ADDR_W-1:0] delta;
        int                         hit;
        r = '{status: sat_pkg::ST_NOT_FOUND, translated: '0, cache_hit: 1'b0};
        hit = -1;
        for (int i = 0; i < mru_list.size() && i < sat_pkg::CACHE_DEPTH && hit < 0; i++)
        begin
            if (int'(mru_list[i]) < sat_pkg::SEGMENT_SLOTS && seg_covers(mru_list[i], addr))
            begin
                hit = mru_list[i];
                r.cache_hit = 1'b1;
            end
        end
        if (hit < 0)
        begin
            for (int i = 0; i < sat_pkg::SEGMENT_SLOTS && hit < 0; i++)
                if (seg_covers(i, addr))
                    hit = i;
            if (hit >= 0)
            begin
                // A full list loses its oldest ordinal before the new one goes in front.
                while (mru_list.size() > sat_pkg::CACHE_DEPTH - 1)
                    void'(mru_list.pop_back());
                if (mru_list.size() == 0 || int'(mru_list[0]) != hit)
                    mru_list = {sat_pkg::ORD_W'(hit), mru_list};
            end
        end
        if (hit >= 0)
        begin
            delta = addr - seg_tab[hit].base;
            r.status = sat_pkg::ST_OK;
            r.translated = seg_tab[hit].mapped + sat_pkg::HOST_W'(delta);
        end
        return r;
    endfunction

    function automatic xlate_result_t predict_command(
        input logic [1:0]                 op,
        input logic [sat_pkg::ORD_W-1:0]  ord,
        input logic [sat_pkg::ADDR_W-1:0] sbase,
        input logic [sat_pkg::ADDR_W-1:0] ssize,
        input logic [sat_pkg::HOST_W-1:0] mbase,
        input logic [sat_pkg::ADDR_W-1:0] addr,
        input logic [sat_pkg::ADDR_W-1:0] ofs
    );
        xlate_result_t r;
        r = '{status: sat_pkg::ST_OK, translated: '0, cache_hit: 1'b0};
        case (op)
            sat_pkg::OP_LOAD:
            begin
                if (int'(ord) < sat_pkg::SEGMENT_SLOTS)
                begin
                    if (seg_valid[ord])
                        r.status = sat_pkg::ST_DUPLICATE;
                    else
                    begin
                        seg_valid[ord] = 1'b1;
                        seg_tab[ord] = '{base: sbase, size: ssize, mapped: mbase};
                    end
                end
            end
            sat_pkg::OP_XLATE_ADDR: r = resolve_address(addr);
            sat_pkg::OP_XLATE_OFS:  r = resolve_address(image_base + ofs);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        xlate_result_t want;
        xlate_result_t next;
        if (!rst_n)
        begin
            foreach (seg_valid[i])
                seg_valid[i] = 1'b0;
            mru_list.delete();
            expected_q.delete();
            image_base = '0;
            errors = 0;
            hit_count = 0;
            miss_count = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected result beat: status %0d translated %h hit %0b",
                           res.status, res.translated, res.cache_hit);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res.status !== want.status)
                    begin
                        errors++;
                        $error("status: expected %0d, got %0d", want.status, res.status);
                    end
                    if (res.translated !== want.translated)
                    begin
                        errors++;
                        $error("translated: expected %h, got %h", want.translated,
                               res.translated);
                    end
                    if (res.cache_hit !== want.cache_hit)
                    begin
                        errors++;
                        $error("cache_hit: expected %0b, got %0b", want.cache_hit,
                               res.cache_hit);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                next = predict_command(cmd.opcode, cmd.ordinal, cmd.segment_base,
                                       cmd.segment_size, cmd.mapped_base, cmd.address,
                                       cmd.offset);
                if (next.cache_hit)
                    hit_count++;
                if (next.status == sat_pkg::ST_NOT_FOUND)
                    miss_count++;
                expected_q.push_back(next);
            end
            if (cfg_write)
                image_base = cfg_data;
        end
        fail_count  <= errors;
        pending     <= expected_q.size();
        recent_hits <= hit_count;
        misses      <= miss_count;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the segment address translator testbench: clock, reset, command and
// image base stimulus under several handshake pressure patterns, and the verdict.
// Depends on sat_pkg, sat_chan_if.sv, the block and sat_xlate_checker.
module testbench;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RESERVED_ORDS  = 4;
    localparam int         FREE_ORDS      = sat_pkg::SEGMENT_SLOTS - RESERVED_ORDS;
    localparam int         RANDOM_ITEMS   = 950;
    localparam int         PHASES         = 8;
    localparam int         CYCLE_LIMIT    = 1_000_000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [sat_pkg::ADDR_W-1:0] cfg_data;

    sat_cmd_if cmd_ch ();
    sat_res_if res_ch ();

    int fail_count;
    int pending;
    int recent_hits;
    int misses;

    int                         idle_pct = 0;
    int                         stall_pct = 0;
    int                         cycle_count = 0;
    int                         sent_count = 0;
    int                         load_count = 0;
    int                         fresh_left = FREE_ORDS;
    logic [sat_pkg::ADDR_W-1:0] cur_image_base = '0;
    bit                         seg_known [sat_pkg::SEGMENT_SLOTS];
    logic [sat_pkg::ADDR_W-1:0] seg_lo [sat_pkg::SEGMENT_SLOTS];
    logic [sat_pkg::ADDR_W-1:0] seg_len [sat_pkg::SEGMENT_SLOTS];
    logic [sat_pkg::ORD_W-1:0]  loaded_ords [$];
    logic [sat_pkg::ORD_W-1:0]  hot_ords [$];

    segment_address_translator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    sat_xlate_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .recent_hits (recent_hits),
        .misses      (misses)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [sat_pkg::HOST_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [sat_pkg::ORD_W-1:0] rand_ord();
        return sat_pkg::ORD_W'($urandom);
    endfunction

    task automatic send_cmd(
        input logic [1:0]                 op,
        input logic [sat_pkg::ORD_W-1:0]  ord,
        input logic [sat_pkg::ADDR_W-1:0] sbase,
        input logic [sat_pkg::ADDR_W-1:0] ssize,
        input logic [sat_pkg::HOST_W-1:0] mbase,
        input logic [sat_pkg::ADDR_W-1:0] addr,
        input logic [sat_pkg::ADDR_W-1:0] ofs
    );
        if (roll(idle_pct))
        begin
            cmd_ch.valid <= 1'b0;
            do @(posedge clk); while (roll(idle_pct));
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.ordinal      <= ord;
        cmd_ch.segment_base <= sbase;
        cmd_ch.segment_size <= ssize;
        cmd_ch.mapped_base  <= mbase;
        cmd_ch.address      <= addr;
        cmd_ch.offset       <= ofs;
        do @(posedge clk); while (!cmd_ch.ready);
        sent_count++;
        if (op == sat_pkg::OP_LOAD)
        begin
            load_count++;
            if (!seg_known[ord])
            begin
                seg_known[ord] = 1'b1;
                seg_lo[ord] = sbase;
                seg_len[ord] = ssize;
                loaded_ords.push_back(ord);
                if (int'(ord) < FREE_ORDS)
                    fresh_left--;
            end
        end
    endtask

    task automatic load_seg(
        input logic [sat_pkg::ORD_W-1:0]  ord,
        input logic [sat_pkg::ADDR_W-1:0] sbase,
        input logic [sat_pkg::ADDR_W-1:0] ssize,
        input logic [sat_pkg::HOST_W-1:0] mbase
    );
        send_cmd(sat_pkg::OP_LOAD, ord, sbase, ssize, mbase, $urandom, $urandom);
    endtask

    task automatic xlate(input logic [sat_pkg::ADDR_W-1:0] addr, input bit use_ofs);
        if (use_ofs)
            send_cmd(sat_pkg::OP_XLATE_OFS, rand_ord(), $urandom, $urandom, rand64(),
                     $urandom, addr - cur_image_base);
        else
            send_cmd(sat_pkg::OP_XLATE_ADDR, rand_ord(), $urandom, $urandom, rand64(),
                     addr, $urandom);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_image_base(input logic [sat_pkg::ADDR_W-1:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_image_base = value;
    endtask

    task automatic random_load();
        logic [sat_pkg::ORD_W-1:0]  ord;
        logic [sat_pkg::ADDR_W-1:0] base;
        logic [sat_pkg::ADDR_W-1:0] size;
        logic [sat_pkg::HOST_W-1:0] mapped;
        int                         shape;
        if (fresh_left > 0 && roll(80))
            do ord = sat_pkg::ORD_W'($urandom_range(0, FREE_ORDS - 1));
            while (seg_known[ord]);
        else
            ord = sat_pkg::ORD_W'($urandom_range(0, sat_pkg::SEGMENT_SLOTS - 1));
        shape = $urandom_range(0, 9);
        if (shape < 5)
        begin
            // Each ordinal owns its own region, so these segments never overlap.
            base = {ord, 2'b00, 24'($urandom)};
            size = $urandom_range(1, 32'h0001_0000);
        end
        else if (shape < 8)
        begin
            base = 32'h4000_0000 + $urandom_range(0, 32'h0003_0000);
            size = $urandom_range(1, 32'h0002_0000);
        end
        else if (shape < 9)
        begin
            base = $urandom;
            size = $urandom_range(0, 1);
        end
        else
        begin
            base = $urandom;
            size = $urandom >> $urandom_range(4, 16);
        end
        mapped = roll(10) ? ~sat_pkg::HOST_W'($urandom_range(0, 1000)) : rand64();
        load_seg(ord, base, size, mapped);
    endtask

    task automatic random_xlate();
        logic [sat_pkg::ADDR_W-1:0] addr;
        logic [sat_pkg::ORD_W-1:0]  ord;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 15 || loaded_ords.size() == 0)
            addr = $urandom;
        else
        begin
            if (pick < 50 && hot_ords.size() > 0)
                ord = hot_ords[$urandom_range(0, hot_ords.size() - 1)];
            else
                ord = loaded_ords[$urandom_range(0, loaded_ords.size() - 1)];
            case ($urandom_range(0, 5))
                0: addr = seg_lo[ord];
                1: addr = seg_lo[ord] + seg_len[ord] - 1;
                2: addr = seg_lo[ord] + seg_len[ord];
                default: addr = seg_lo[ord]
                                + ((seg_len[ord] == 0) ? 32'd0 : $urandom % seg_len[ord]);
            endcase
            hot_ords = {ord, hot_ords};
            if (hot_ords.size() > 6)
                void'(hot_ords.pop_back());
        end
        xlate(addr, roll(50));
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [sat_pkg::ADDR_W-1:0] plan_base;
        int                         mode;
        int                         pick;
        rst_n               <= 1'b0;
        cfg_write           <= 1'b0;
        cfg_data            <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.opcode       <= sat_pkg::OP_LOAD;
        cmd_ch.ordinal      <= '0;
        cmd_ch.segment_base <= '0;
        cmd_ch.segment_size <= '0;
        cmd_ch.mapped_base  <= '0;
        cmd_ch.address      <= '0;
        cmd_ch.offset       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, range extremes, duplicates, list order.
        set_image_base(32'h1000_0000);
        xlate(32'h0000_0000, 1'b0);
        load_seg(6'd63, 32'hFFFF_FF00, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF80);
        load_seg(6'd62, 32'h0000_4000, 32'h0000_0000, rand64());
        load_seg(6'd61, 32'h0000_0000, 32'h0000_0001, 64'h0);
        load_seg(6'd0, 32'h0001_0000, 32'h0000_1000, 64'h1234_5678_9ABC_0000);
        load_seg(6'd0, 32'h0002_0000, 32'h0000_0010, rand64());
        xlate(32'hFFFF_FFFF, 1'b0);
        xlate(32'hFFFF_FF00, 1'b1);
        xlate(32'h0000_0000, 1'b0);
        xlate(32'h0000_4000, 1'b0);
        xlate(32'h0001_0800, 1'b1);
        xlate(32'h0001_0FFF, 1'b1);
        xlate(32'h0001_1000, 1'b0);
        send_cmd(OP_UNUSED, rand_ord(), $urandom, $urandom, rand64(), $urandom, $urandom);
        load_seg(6'd1, 32'h0001_0800, 32'h0000_2000, rand64());
        xlate(32'h0001_0900, 1'b0);
        xlate(32'h0001_2000, 1'b0);
        xlate(32'h0001_0900, 1'b1);
        send_cmd(sat_pkg::OP_XLATE_OFS, rand_ord(), $urandom, $urandom, rand64(), $urandom,
                 32'h7FFF_FFFF);
        send_cmd(sat_pkg::OP_XLATE_OFS, rand_ord(), $urandom, $urandom, rand64(), $urandom,
                 32'h8000_0000);
        load_seg(6'd2, 32'h2000_0000, 32'h0000_0100, '1);
        xlate(32'h2000_00FF, 1'b0);
        load_seg(6'd63, 32'h0, 32'h0000_0100, rand64());

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: plan_base = 32'h0000_0000;
                1: plan_base = 32'hFFFF_FFFF;
                2: plan_base = 32'h8000_0000;
                3: plan_base = 32'h7FFF_FFFF;
                4: plan_base = 32'h0000_0001;
                default: plan_base = $urandom;
            endcase
            set_image_base(plan_base);
            mode = p % 4;
            idle_pct  = (mode == 1) ? 73 : ((mode == 3) ? 35 : 0);
            stall_pct = (mode == 2) ? 73 : ((mode == 3) ? 35 : 0);
            repeat (RANDOM_ITEMS / PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 14)
                    random_load();
                else if (pick < 17)
                    send_cmd(OP_UNUSED, rand_ord(), $urandom, $urandom, rand64(), $urandom,
                             $urandom);
                else
                    random_xlate();
            end
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Run covered %0d commands, %0d of them segment loads,", sent_count,
                 load_count);
        $display("under %0d image base values, with %0d recent-list hits and %0d misses.",
                 PHASES + 1, recent_hits, misses);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
